// ----- design/latg_pkg.sv -----
// ============================================================================
// latg_pkg
// Shared types and constants for the lock actuation thermal guard.
// ============================================================================
package latg_pkg;

    localparam int unsigned SlotsDefault = 10;

    localparam int unsigned CmdW   = 8;
    localparam int unsigned TimerW = 16;
    localparam int unsigned CountW = 8;

    localparam logic [TimerW-1:0] WindowTicksRst  = 16'd1250;
    localparam logic [CountW-1:0] CountLimitRst   = 8'd10;
    localparam logic [TimerW-1:0] LockoutTicksRst = 16'd7500;

    localparam int unsigned ApbDataW = 32;
    localparam int unsigned ApbAddrW = 4;

    typedef enum logic [1:0] {
        REG_WINDOW_TICKS  = 2'd0,
        REG_COUNT_LIMIT   = 2'd1,
        REG_LOCKOUT_TICKS = 2'd2
    } t_reg_idx;

endpackage

// ----- design/latg_if.sv -----
// ============================================================================
// latg_if
// Valid/ready channels for command words in and guard result words out.
// ============================================================================
interface latg_cmd_if
    import latg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CmdW-1:0]   command_code;

    modport source (output valid, output command_code, input ready);
    modport sink   (input valid, input command_code, output ready);
endinterface

interface latg_res_if
    import latg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              lockout_active;
    logic [TimerW-1:0] lockout_remaining;
    logic              tripped;

    modport source (output valid, output lockout_active, output lockout_remaining,
                    output tripped, input ready);
    modport sink   (input valid, input lockout_active, input lockout_remaining,
                    input tripped, output ready);
endinterface

// ----- design/lock_actuation_thermal_guard.sv -----
// ============================================================================
// lock_actuation_thermal_guard
// Counts lock actuator actuations in sliding windows and raises a thermal
// lockout when too many occur.
// ============================================================================
// Each command word is one tick. A change of command code to a nonzero value
// is an actuation: it advances a ring of SLOTS windows and loads the new slot
// with window_ticks, and every open window then counts the actuation. A window
// whose count goes above count_limit is closed and starts the lockout timer at
// lockout_ticks. All windows update side by side in a single combinational
// pass between the accepted word and the result register, so the block takes
// one word every clock cycle while results are taken and returns its result
// word on the following cycle; the result register frees itself as its word
// is taken, so input and output may both stream at full rate. The user must
// write registers over the APB port while the block is idle (not enforced).
module lock_actuation_thermal_guard
    import latg_pkg::*;
#(
    parameter int unsigned SLOTS = SlotsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    latg_cmd_if.sink            i_cmd,
    latg_res_if.source          o_res,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    localparam int unsigned PtrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [PtrW-1:0] LastSlot = PtrW'(SLOTS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TimerW-1:0] r_window_ticks;
    logic [CountW-1:0] r_count_limit;
    logic [TimerW-1:0] r_lockout_ticks;
    t_reg_idx          w_reg_idx;
    logic              w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks  <= WindowTicksRst;
            r_count_limit   <= CountLimitRst;
            r_lockout_ticks <= LockoutTicksRst;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_WINDOW_TICKS:  r_window_ticks  <= pwdata[TimerW-1:0];
                REG_COUNT_LIMIT:   r_count_limit   <= pwdata[CountW-1:0];
                REG_LOCKOUT_TICKS: r_lockout_ticks <= pwdata[TimerW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_WINDOW_TICKS:  prdata = ApbDataW'(r_window_ticks);
            REG_COUNT_LIMIT:   prdata = ApbDataW'(r_count_limit);
            REG_LOCKOUT_TICKS: prdata = ApbDataW'(r_lockout_ticks);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: the result register accepts a new word whenever it is
    // empty or its current word leaves in this cycle.
    // ------------------------------------------------------------------
    logic r_res_valid;
    logic w_accept;

    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // ------------------------------------------------------------------
    // Guard state
    // ------------------------------------------------------------------
    logic [CmdW-1:0]   r_prev_cmd;
    logic [PtrW-1:0]   r_ring_ptr;
    logic [TimerW-1:0] r_window_timer [SLOTS];
    logic [CountW-1:0] r_act_count    [SLOTS];
    logic [TimerW-1:0] r_lockout_timer;

    logic              w_actuation;
    logic [PtrW-1:0]   n_ring_ptr;
    logic [TimerW-1:0] n_window_timer [SLOTS];
    logic [CountW-1:0] n_act_count    [SLOTS];
    logic [TimerW-1:0] n_lockout_timer;
    logic              n_tripped;

    // One pass over all slots; each slot depends only on its own state, the
    // settings, the actuation flag and new pointer, so the loop is parallel.
    always_comb begin
        logic [TimerW-1:0] wt;
        logic [CountW-1:0] cnt;
        logic [TimerW-1:0] lt;

        w_actuation = (i_cmd.command_code != r_prev_cmd) && (i_cmd.command_code != '0);
        n_ring_ptr  = r_ring_ptr;
        if (w_actuation) begin
            n_ring_ptr = (r_ring_ptr == LastSlot) ? '0 : r_ring_ptr + PtrW'(1);
        end

        n_tripped = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            wt  = r_window_timer[i];
            cnt = r_act_count[i];
            if (w_actuation) begin
                if (n_ring_ptr == PtrW'(i)) begin
                    wt = r_window_ticks;
                end
                if (wt != '0) begin
                    if (cnt != '1) begin
                        cnt = cnt + CountW'(1);
                    end
                    if (cnt > r_count_limit) begin
                        wt        = '0;
                        cnt       = '0;
                        n_tripped = 1'b1;
                    end
                end
            end
            if (wt != '0) begin
                wt = wt - TimerW'(1);
            end else begin
                cnt = '0;
            end
            n_window_timer[i] = wt;
            n_act_count[i]    = cnt;
        end

        lt = n_tripped ? r_lockout_ticks : r_lockout_timer;
        if (lt != '0) begin
            lt = lt - TimerW'(1);
        end
        n_lockout_timer = lt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cmd      <= '0;
            r_ring_ptr      <= '0;
            r_lockout_timer <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_window_timer[i] <= '0;
                r_act_count[i]    <= '0;
            end
        end else if (w_accept) begin
            r_prev_cmd      <= i_cmd.command_code;
            r_ring_ptr      <= n_ring_ptr;
            r_lockout_timer <= n_lockout_timer;
            for (int i = 0; i < SLOTS; i++) begin
                r_window_timer[i] <= n_window_timer[i];
                r_act_count[i]    <= n_act_count[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic              r_lockout_active;
    logic [TimerW-1:0] r_lockout_remaining;
    logic              r_tripped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lockout_active    <= (n_lockout_timer != '0);
            r_lockout_remaining <= n_lockout_timer;
            r_tripped           <= n_tripped;
        end
    end

    assign o_res.valid             = r_res_valid;
    assign o_res.lockout_active    = r_lockout_active;
    assign o_res.lockout_remaining = r_lockout_remaining;
    assign o_res.tripped           = r_tripped;

`ifndef SYNTHESIS
    // The ring pointer never leaves the slot range.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring_ptr <= LastSlot)
        else $error("ring pointer out of range");

    // A trip is reported in the result word that follows the accepted word.
    a_trip_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_tripped |=> o_res.valid && o_res.tripped)
        else $error("trip not reported");

    // The lockout timer changes only when a command word is accepted.
    a_lockout_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_lockout_timer))
        else $error("lockout timer moved without a command word");

    // A waiting result word holds still until it is taken.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.lockout_active)
            && $stable(o_res.lockout_remaining) && $stable(o_res.tripped))
        else $error("waiting result word changed");
`endif

endmodule
